[hdl/button_debounce_hold_tracker_macros.svh]
// assertion macros for the button debounce hold tracker
// expects clk and arst_n in the scope of use
`ifndef BUTTON_DEBOUNCE_HOLD_TRACKER_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_TRACKER_MACROS_SVH

// same-cycle implication
`define BDHT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BDHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bdht_pkg.sv]
// shared types, constants and helpers of the button debounce hold tracker
// no dependencies
`default_nettype none

package bdht_pkg;

	localparam int IDX_W  = 2;
	localparam int DT_W   = 16;
	localparam int WORD_W = 32;
	localparam int POL_W  = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [WORD_W-1:0] WORD_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLARITY_MASK  = 1'b1;

	typedef enum logic [1:0] {
		PH_WAIT_PRESS     = 2'd0,
		PH_PRESS_STABLE   = 2'd1,
		PH_WAIT_RELEASE   = 2'd2,
		PH_RELEASE_STABLE = 2'd3
	} phase_t;

	// one memory word of per-button state
	typedef struct packed {
		phase_t            phase;
		logic [WORD_W-1:0] stable_timer;
		logic [WORD_W-1:0] hold_accum;
		logic              held_flag;
		logic              pending_flag;
		logic [WORD_W-1:0] press_counter;
		logic [WORD_W-1:0] release_counter;
		logic [WORD_W-1:0] latched_hold;
	} btn_state_t;

	// saturating add of a delta onto a 32-bit accumulator
	function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
			input logic [DT_W-1:0] b);
		logic [WORD_W:0] sum;
		sum = {1'b0, a} + {{(WORD_W+1-DT_W){1'b0}}, b};
		return sum[WORD_W] ? WORD_MAX : sum[WORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

[hdl/bdht_sample_if.sv]
// input channel of the button debounce hold tracker: one pin sample per beat
// depends on bdht_pkg
`default_nettype none

interface bdht_sample_if
	import bdht_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] button_index;
	logic             raw_level;
	logic [DT_W-1:0]  elapsed_ms;

	modport source (output valid, button_index, raw_level, elapsed_ms, input ready);
	modport sink (input valid, button_index, raw_level, elapsed_ms, output ready);
endinterface

`default_nettype wire

[hdl/bdht_status_if.sv]
// output channel of the button debounce hold tracker: one button snapshot per beat
// depends on bdht_pkg
`default_nettype none

interface bdht_status_if
	import bdht_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  button_id_out;
	logic              is_held;
	logic              release_waiting;
	logic [WORD_W-1:0] press_count;
	logic [WORD_W-1:0] release_count;
	logic [WORD_W-1:0] last_hold_ms;

	modport source (output valid, button_id_out, is_held, release_waiting, press_count,
		release_count, last_hold_ms, input ready);
	modport sink (input valid, button_id_out, is_held, release_waiting, press_count,
		release_count, last_hold_ms, output ready);
endinterface

`default_nettype wire

[hdl/button_debounce_hold_tracker.sv]
// Button debounce and hold tracker. Takes one pin sample beat per clock unless stalled
// and returns one snapshot beat per sample, in order, via stage 1 and the output
// register. Per-button state lives in a one-port-read, one-port-write state memory with
// registered read data; each sample is a read in the cycle it is accepted and a write-back
// when stage 1 advances. Same-button samples may follow each other back to back: the word
// being written is forwarded to the read that happens on the same edge. Sustained rate is
// one sample per cycle while the status side keeps up; state is zero right after reset
// with no clearing pass. Write configuration only while no beat is in flight.
// Depends on bdht_pkg, bdht_sample_if, bdht_status_if and the assertion macro header.
`default_nettype none

module button_debounce_hold_tracker
	import bdht_pkg::*;
#(
	parameter int NUM_BUTTONS = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data,
	bdht_sample_if.sink               sample,
	bdht_status_if.source             status
);

	localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	// configuration
	logic [WORD_W-1:0] limit_q;
	logic [POL_W-1:0]  polarity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= '0;
			polarity_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE_LIMIT: limit_q    <= cfg_data;
				CFG_POLARITY_MASK:  polarity_q <= cfg_data[POL_W-1:0];
			endcase
		end
	end

	// handshake and stage control
	logic v_s1;
	logic out_valid_q;
	logic advance;
	logic accept;

	assign advance      = !out_valid_q || status.ready;
	assign sample.ready = !v_s1 || advance;
	assign accept       = sample.valid && sample.ready;

	// read address
	logic [AW+IDX_W-1:0] idx_ext;
	logic [AW-1:0]       raddr;
	logic                rd_in_range;

	assign idx_ext     = {{AW{1'b0}}, sample.button_index};
	assign raddr       = idx_ext[AW-1:0];
	assign rd_in_range = int'(sample.button_index) < NUM_BUTTONS;

	// stage 1 registers
	logic [IDX_W-1:0] idx_s1;
	logic [AW-1:0]    addr_s1;
	logic             level_s1;
	logic [DT_W-1:0]  dt_s1;
	logic             in_range_s1;
	logic             byp_s1;
	logic             vld_s1;
	btn_state_t       byp_data_s1;
	btn_state_t       rd_s1;

	// write-back
	logic       wr_en;
	btn_state_t nxt;

	btn_state_t       mem [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= nxt;
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sample.ready) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1      <= sample.button_index;
			addr_s1     <= raddr;
			level_s1    <= sample.raw_level;
			dt_s1       <= sample.elapsed_ms;
			in_range_s1 <= rd_in_range;
			// same button written back on this edge: take the new word
			byp_s1      <= wr_en && (addr_s1 == raddr);
			byp_data_s1 <= nxt;
			vld_s1      <= rd_in_range && vld_q[raddr];
		end
	end

	// stage 1 update
	btn_state_t        cur;
	logic              pressed;
	logic [WORD_W-1:0] timer_sum;
	logic [WORD_W-1:0] hold_sum;

	assign wr_en = v_s1 && advance && in_range_s1;

	always_comb begin
		if (byp_s1) begin
			cur = byp_data_s1;
		end else if (vld_s1) begin
			cur = rd_s1;
		end else begin
			cur = '0;
		end

		pressed   = level_s1 ^ polarity_q[idx_s1];
		timer_sum = sat_add(cur.stable_timer, dt_s1);
		hold_sum  = sat_add(cur.hold_accum, dt_s1);
		nxt       = cur;

		unique case (cur.phase)
			PH_WAIT_PRESS: begin
				if (pressed) begin
					nxt.stable_timer = '0;
					nxt.phase        = PH_PRESS_STABLE;
				end
			end
			PH_PRESS_STABLE: begin
				if (!pressed) begin
					nxt.phase = PH_WAIT_PRESS;
				end else begin
					nxt.stable_timer = timer_sum;
					if (timer_sum >= limit_q) begin
						nxt.hold_accum    = timer_sum;
						nxt.held_flag     = 1'b1;
						nxt.press_counter = cur.press_counter + 1'b1;
						nxt.phase         = PH_WAIT_RELEASE;
					end
				end
			end
			PH_WAIT_RELEASE: begin
				if (pressed) begin
					nxt.hold_accum = hold_sum;
				end else begin
					nxt.stable_timer = '0;
					nxt.phase        = PH_RELEASE_STABLE;
				end
			end
			PH_RELEASE_STABLE: begin
				if (pressed) begin
					nxt.stable_timer = '0;
					nxt.phase        = PH_WAIT_RELEASE;
				end else begin
					nxt.stable_timer = timer_sum;
					if (timer_sum >= limit_q) begin
						nxt.held_flag       = 1'b0;
						nxt.latched_hold    = cur.hold_accum;
						nxt.release_counter = cur.release_counter + 1'b1;
						nxt.phase           = PH_WAIT_PRESS;
					end
				end
			end
		endcase

		nxt.pending_flag = pressed || (nxt.phase != PH_WAIT_PRESS);
	end

	// output register
	logic [IDX_W-1:0]  id_q;
	logic              held_q;
	logic              waiting_q;
	logic [WORD_W-1:0] press_q;
	logic [WORD_W-1:0] release_q;
	logic [WORD_W-1:0] hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			id_q <= idx_s1;
			if (in_range_s1) begin
				held_q    <= nxt.held_flag;
				waiting_q <= nxt.pending_flag;
				press_q   <= nxt.press_counter;
				release_q <= nxt.release_counter;
				hold_q    <= nxt.latched_hold;
			end else begin
				held_q    <= 1'b0;
				waiting_q <= 1'b0;
				press_q   <= '0;
				release_q <= '0;
				hold_q    <= '0;
			end
		end
	end

	assign status.valid           = out_valid_q;
	assign status.button_id_out   = id_q;
	assign status.is_held         = held_q;
	assign status.release_waiting = waiting_q;
	assign status.press_count     = press_q;
	assign status.release_count   = release_q;
	assign status.last_hold_ms    = hold_q;

	`include "button_debounce_hold_tracker_macros.svh"

	`BDHT_ASSERT_NOW(a_held_implies_waiting, status.valid && status.is_held,
		status.release_waiting, "held button reported without release pending")
	`BDHT_ASSERT_NEXT(a_accept_fills_s1, accept, v_s1,
		"accepted sample did not reach stage 1")
	`BDHT_ASSERT_NEXT(a_s1_holds_on_stall, v_s1 && !advance,
		v_s1 && $stable(idx_s1) && $stable(dt_s1), "stage 1 changed while stalled")

endmodule

`default_nettype wire
